// ----- design/pol_pkg.sv -----
`timescale 1ns / 1ps

package pol_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

// ----- design/pol_cell.sv -----
`timescale 1ns / 1ps

module pol_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pol_pkg::cell_cmd_t                  cmd,
    input  logic [IDX_W-1:0]                    idx,
    input  logic signed [pol_pkg::VALUE_W-1:0]  new_val,
    input  logic signed [pol_pkg::VALUE_W-1:0]  left_val,
    input  logic                                left_occ,
    input  logic signed [pol_pkg::VALUE_W-1:0]  right_val,
    input  logic                                right_occ,
    output logic signed [pol_pkg::VALUE_W-1:0]  val,
    output logic                                occ,
    output logic                                tail
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [pol_pkg::VALUE_W-1:0] val_reg;
    logic                               occ_reg;

    // occupancy is a thermometer from the front
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else if (cmd.ins) begin
            occ_reg <= occ_reg | left_occ;
        end else if (cmd.del) begin
            occ_reg <= right_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins) begin
            if (MY_IDX > idx) begin
                val_reg <= left_val;
            end else if (MY_IDX == idx) begin
                val_reg <= new_val;
            end
        end else if (cmd.del) begin
            if (MY_IDX >= idx) begin
                val_reg <= right_val;
            end
        end
    end

    assign val  = val_reg;
    assign occ  = occ_reg;
    assign tail = occ_reg & ~right_occ;

endmodule

// ----- design/positional_ordered_list.sv -----
`timescale 1ns / 1ps
// Channel | Ports                                          | Direction
// s_      | s_opcode, s_value, s_position, s_valid/s_ready | request in
// m_      | m_status, m_count, m_first_value, m_last_value | result out
//
// The cell row shifts at the accepting edge; once m_ is free, a later edge
// registers the result from the cell row (front cell and tail cell).
// One item in flight; a new item is taken while a result waits on m_.
// Reset (aresetn low, synchronous) empties the list; no clearing pass.
// A stalled result holds; the pending item waits until the result is taken.

module positional_ordered_list #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pol_pkg::OP_W-1:0]              s_opcode,
    input  logic signed [pol_pkg::VALUE_W-1:0]    s_value,
    input  logic [pol_pkg::POS_W-1:0]             s_position,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [pol_pkg::STATUS_W-1:0]          m_status,
    output logic [pol_pkg::COUNT_W-1:0]           m_count,
    output logic signed [pol_pkg::VALUE_W-1:0]    m_first_value,
    output logic signed [pol_pkg::VALUE_W-1:0]    m_last_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W + 1 > pol_pkg::POS_W) ? CNT_W + 1 : pol_pkg::POS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic                              pend_reg;
    logic [pol_pkg::STATUS_W-1:0]      st_pend_reg;
    logic                              m_valid_reg;
    logic [pol_pkg::STATUS_W-1:0]      m_status_reg;
    logic [pol_pkg::COUNT_W-1:0]       m_count_reg;
    logic signed [pol_pkg::VALUE_W-1:0] m_first_reg, m_last_reg;

    logic                              s_acc, load;
    logic                              full, empty;
    logic [CMP_W-1:0]                  pos_c, cnt_c, idx_c;
    logic [pol_pkg::STATUS_W-1:0]      st;
    logic                              do_ins, do_del;
    pol_pkg::cell_cmd_t                cmd;
    logic [IDX_W-1:0]                  idx;

    logic signed [pol_pkg::VALUE_W-1:0] val_vec [CAPACITY];
    logic [CAPACITY-1:0]               occ_vec, tail_vec;
    logic signed [pol_pkg::VALUE_W-1:0] last_sel;

    assign s_ready = ~pend_reg;
    assign s_acc   = s_valid & s_ready;
    assign load    = pend_reg & (~m_valid_reg | m_ready);

    assign full  = (cnt_reg == CNT_MAX);
    assign empty = (cnt_reg == '0);
    assign pos_c = CMP_W'(s_position);
    assign cnt_c = CMP_W'(cnt_reg);

    always_comb begin
        st     = pol_pkg::ST_DONE;
        do_ins = 1'b0;
        do_del = 1'b0;
        idx_c  = '0;
        unique case (s_opcode)
            pol_pkg::OP_INS_FRONT: begin
                if (full) st = pol_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            pol_pkg::OP_INS_BACK: begin
                idx_c = cnt_c;
                if (full) st = pol_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            pol_pkg::OP_INS_POS: begin
                idx_c = pos_c - CMP_W'(1);
                if (full) st = pol_pkg::ST_FULL;
                else if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) st = pol_pkg::ST_RANGE;
                else do_ins = 1'b1;
            end
            pol_pkg::OP_DEL_FRONT: begin
                if (empty) st = pol_pkg::ST_EMPTY;
                else do_del = 1'b1;
            end
            pol_pkg::OP_DEL_BACK: begin
                idx_c = cnt_c - CMP_W'(1);
                if (empty) st = pol_pkg::ST_EMPTY;
                else do_del = 1'b1;
            end
            pol_pkg::OP_DEL_POS: begin
                idx_c = pos_c - CMP_W'(1);
                if (empty) st = pol_pkg::ST_EMPTY;
                else if (pos_c == '0 || pos_c > cnt_c) st = pol_pkg::ST_RANGE;
                else do_del = 1'b1;
            end
            default: begin
                st = pol_pkg::ST_RANGE;
            end
        endcase
    end

    assign cmd.ins = s_acc & do_ins;
    assign cmd.del = s_acc & do_del;
    assign idx     = idx_c[IDX_W-1:0];

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.ins) cnt_next = cnt_reg + CNT_W'(1);
        else if (cmd.del) cnt_next = cnt_reg - CNT_W'(1);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [pol_pkg::VALUE_W-1:0] lv, rv;
            logic                               lo, ro;
            if (g == 0) begin : g_head
                assign lv = s_value;
                assign lo = 1'b1;
            end else begin : g_mid
                assign lv = val_vec[g-1];
                assign lo = occ_vec[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign rv = val_vec[g];
                assign ro = 1'b0;
            end else begin : g_link
                assign rv = val_vec[g+1];
                assign ro = occ_vec[g+1];
            end
            pol_cell #(
                .IDX_W (IDX_W),
                .INDEX (g)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .idx       (idx),
                .new_val   (s_value),
                .left_val  (lv),
                .left_occ  (lo),
                .right_val (rv),
                .right_occ (ro),
                .val       (val_vec[g]),
                .occ       (occ_vec[g]),
                .tail      (tail_vec[g])
            );
        end
    endgenerate

    always_comb begin
        last_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            last_sel = last_sel | (val_vec[i] & {pol_pkg::VALUE_W{tail_vec[i]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_acc) begin
                pend_reg    <= 1'b1;
                st_pend_reg <= st;
            end else if (load) begin
                pend_reg <= 1'b0;
            end
            if (load) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= st_pend_reg;
                m_count_reg  <= pol_pkg::COUNT_W'(cnt_reg);
                m_first_reg  <= empty ? '0 : val_vec[0];
                m_last_reg   <= empty ? '0 : last_sel;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_count       = m_count_reg;
    assign m_first_value = m_first_reg;
    assign m_last_value  = m_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("element count above capacity");

    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == int'(cnt_reg))
        else $error("cell occupancy disagrees with count");

    a_tail_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tail_vec) && ((cnt_reg == '0) || $onehot(tail_vec)))
        else $error("tail cell not unique");

    a_accept_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> pend_reg || m_valid_reg)
        else $error("accepted item lost");
`endif

endmodule

// ----- tb/positional_ordered_list_tb.sv -----
`timescale 1ns / 1ps

module positional_ordered_list_tb;

    localparam int LIST_CAP     = pol_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [pol_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [pol_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic signed [pol_pkg::VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [pol_pkg::VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [pol_pkg::VALUE_W-1:0] VAL_ODD  = 32'sh5555_5555;
    localparam logic signed [pol_pkg::VALUE_W-1:0] VAL_EVEN = 32'shAAAA_AAAA;

    typedef struct {
        logic [pol_pkg::STATUS_W-1:0]       status;
        logic [pol_pkg::COUNT_W-1:0]        count;
        logic signed [pol_pkg::VALUE_W-1:0] first_value;
        logic signed [pol_pkg::VALUE_W-1:0] last_value;
    } list_summary_t;

    logic                                aclk       = 1'b0;
    logic                                aresetn    = 1'b0;
    logic                                s_valid    = 1'b0;
    logic                                s_ready;
    logic [pol_pkg::OP_W-1:0]            s_opcode   = pol_pkg::OP_INS_FRONT;
    logic signed [pol_pkg::VALUE_W-1:0]  s_value    = '0;
    logic [pol_pkg::POS_W-1:0]           s_position = '0;
    logic                                m_valid;
    logic                                m_ready    = 1'b0;
    logic [pol_pkg::STATUS_W-1:0]        m_status;
    logic [pol_pkg::COUNT_W-1:0]         m_count;
    logic signed [pol_pkg::VALUE_W-1:0]  m_first_value;
    logic signed [pol_pkg::VALUE_W-1:0]  m_last_value;

    logic signed [pol_pkg::VALUE_W-1:0]  shadow_list[$];
    list_summary_t                       pending_results[$];
    int                                  mismatch_cnt = 0;
    int                                  tx_idle_pct  = 0;
    int                                  rx_stall_pct = 0;
    int                                  quiet_cycles = 0;

    positional_ordered_list #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_first_value(m_first_value),
        .m_last_value (m_last_value)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic list_summary_t predict_request(
        input logic [pol_pkg::OP_W-1:0]           op,
        input logic signed [pol_pkg::VALUE_W-1:0] val,
        input logic [pol_pkg::POS_W-1:0]          pos);
        list_summary_t res;
        int            fill;
        bit            full;
        bit            empty;
        fill  = shadow_list.size();
        full  = fill >= LIST_CAP;
        empty = fill == 0;
        res.status = pol_pkg::ST_DONE;
        case (op)
            pol_pkg::OP_INS_FRONT: begin
                if (full) res.status = pol_pkg::ST_FULL;
                else shadow_list.push_front(val);
            end
            pol_pkg::OP_INS_BACK: begin
                if (full) res.status = pol_pkg::ST_FULL;
                else shadow_list.push_back(val);
            end
            pol_pkg::OP_INS_POS: begin
                if (full) res.status = pol_pkg::ST_FULL;
                else if (pos < 1 || pos > fill + 1) res.status = pol_pkg::ST_RANGE;
                else shadow_list.insert(pos - 1, val);
            end
            pol_pkg::OP_DEL_FRONT: begin
                if (empty) res.status = pol_pkg::ST_EMPTY;
                else void'(shadow_list.pop_front());
            end
            pol_pkg::OP_DEL_BACK: begin
                if (empty) res.status = pol_pkg::ST_EMPTY;
                else void'(shadow_list.pop_back());
            end
            pol_pkg::OP_DEL_POS: begin
                if (empty) res.status = pol_pkg::ST_EMPTY;
                else if (pos < 1 || pos > fill) res.status = pol_pkg::ST_RANGE;
                else shadow_list.delete(pos - 1);
            end
            default: res.status = pol_pkg::ST_RANGE;
        endcase
        fill = shadow_list.size();
        res.count = fill[pol_pkg::COUNT_W-1:0];
        res.first_value = (fill == 0) ? '0 : shadow_list[0];
        res.last_value  = (fill == 0) ? '0 : shadow_list[fill-1];
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input longint want, input longint got,
                               input bit differs);
        if (differs) note_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    always @(posedge aclk) begin : check_results
        list_summary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result status %0d count %0d",
                                        m_status, m_count));
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_status, m_status !== want.status);
                check_field("count", want.count, m_count, m_count !== want.count);
                check_field("first_value", want.first_value, m_first_value,
                            m_first_value !== want.first_value);
                check_field("last_value", want.last_value, m_last_value,
                            m_last_value !== want.last_value);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("positional_ordered_list_tb: FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [pol_pkg::OP_W-1:0] op,
                                input logic signed [pol_pkg::VALUE_W-1:0] val,
                                input logic [pol_pkg::POS_W-1:0] pos);
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_value    <= val;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_request(op, val, pos));
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // hold off the sender until every result is back
    task automatic pause_until_drained();
        if (s_valid) s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [pol_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_edge_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_request(pol_pkg::OP_DEL_FRONT, VAL_ODD, 7'd0);
        send_request(pol_pkg::OP_DEL_BACK, VAL_EVEN, 7'd127);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd0);
        send_request(pol_pkg::OP_INS_POS, 32'sd11, 7'd0);
        send_request(pol_pkg::OP_INS_POS, 32'sd12, 7'd2);
        send_request(pol_pkg::OP_INS_POS, VAL_MAX, 7'd1);
        send_request(pol_pkg::OP_INS_FRONT, VAL_MIN, 7'd127);
        send_request(pol_pkg::OP_INS_BACK, -1, 7'd0);
        send_request(pol_pkg::OP_INS_POS, VAL_ODD, 7'd4);
        send_request(pol_pkg::OP_INS_POS, 32'sd13, 7'd6);
        send_request(pol_pkg::OP_INS_POS, 32'sd14, 7'd127);
        send_request(pol_pkg::OP_INS_POS, VAL_EVEN, 7'd2);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd0);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd6);
        send_request(pol_pkg::OP_DEL_POS, -1, 7'd127);
        send_request(OP_UNUSED_6, 32'sd15, 7'd1);
        send_request(OP_UNUSED_7, -1, 7'd127);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd3);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd4);
        send_request(pol_pkg::OP_DEL_BACK, '0, 7'd0);
        send_request(pol_pkg::OP_DEL_FRONT, '0, 7'd0);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd1);
        send_request(pol_pkg::OP_INS_BACK, '0, 7'd0);
        send_request(pol_pkg::OP_DEL_BACK, '0, 7'd0);
        pause_until_drained();
    endtask

    task automatic test_full_list();
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        while (shadow_list.size() < LIST_CAP)
            send_request(pol_pkg::OP_INS_BACK, pick_value(), 7'd0);
        send_request(pol_pkg::OP_INS_FRONT, 32'sd21, 7'd0);
        send_request(pol_pkg::OP_INS_BACK, 32'sd22, 7'd0);
        send_request(pol_pkg::OP_INS_POS, 32'sd23, 7'd0);
        send_request(pol_pkg::OP_INS_POS, 32'sd24, 7'd1);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'd0);
        send_request(pol_pkg::OP_DEL_POS, '0, 7'(LIST_CAP));
        send_request(pol_pkg::OP_INS_POS, 32'sd25, 7'(LIST_CAP));
        send_request(pol_pkg::OP_INS_POS, 32'sd26, 7'd1);
        while (shadow_list.size() > 0) begin
            if ($urandom_range(1)) begin
                send_request(pol_pkg::OP_DEL_FRONT, '0, 7'd0);
            end else begin
                send_request(pol_pkg::OP_DEL_POS, '0,
                             7'($urandom_range(shadow_list.size(), 1)));
            end
        end
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        logic [pol_pkg::OP_W-1:0]  op;
        logic [pol_pkg::POS_W-1:0] pos;
        int                        fill;
        bit                        growing;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        growing      = 1'b1;
        repeat (n_items) begin
            fill = shadow_list.size();
            if (fill >= LIST_CAP) growing = 1'b0;
            else if (fill == 0) growing = 1'b1;
            else if ($urandom_range(49) == 0) growing = !growing;
            if ($urandom_range(9) < 2) begin
                op  = 3'($urandom_range(7));
                pos = 7'($urandom_range(127));
            end else if (($urandom_range(3) != 0) == growing) begin
                case ($urandom_range(2))
                    0: op = pol_pkg::OP_INS_FRONT;
                    1: op = pol_pkg::OP_INS_BACK;
                    default: op = pol_pkg::OP_INS_POS;
                endcase
                pos = 7'($urandom_range(fill + 1, 1));
            end else begin
                case ($urandom_range(2))
                    0: op = pol_pkg::OP_DEL_FRONT;
                    1: op = pol_pkg::OP_DEL_BACK;
                    default: op = pol_pkg::OP_DEL_POS;
                endcase
                pos = (fill == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(fill, 1));
            end
            send_request(op, pick_value(), pos);
        end
        pause_until_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_cases();
        test_full_list();
        test_random_traffic(60, 0, 0);
        test_random_traffic(60, 83, 0);
        test_random_traffic(60, 0, 83);
        test_random_traffic(60, 30, 30);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_cnt == 0) begin
            $display("positional_ordered_list_tb: PASS");
        end else begin
            $display("positional_ordered_list_tb: FAIL");
        end
        $finish;
    end

endmodule
